// ===== hdl/ald_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ald_pkg
// Shared types and constants of the asymmetric level debounce block.
// ----------------------------------------------------------------------------
package ald_pkg;

  localparam int LEVELS     = 3;
  localparam int LEVEL_W    = 2;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);

  localparam logic [CFG_W-1:0] DROP_FRAMES_RST = CFG_W'(3);
  localparam logic [CFG_W-1:0] DROP_HOLD_RST   = CFG_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_FRAMES = 1'b0,
    CFG_DROP_HOLD   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] raw_level;
    logic [TIME_W-1:0]  now_ms;
  } item_t;

endpackage

// ===== hdl/ald_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ald_in_stage
// Input register: captures one word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module ald_in_stage
  import ald_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [LEVEL_W-1:0] in_raw_level,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic               advance,
  output logic               item_valid,
  output item_t              item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt          = 1'b1;
      item_nxt.raw_level = in_raw_level;
      item_nxt.now_ms    = in_now_ms;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/ald_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ald_core
// Debounce state, configuration registers and the single-step update.
// ----------------------------------------------------------------------------
module ald_core
  import ald_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 step,
  input  item_t                item,
  output logic [LEVEL_W-1:0]   level_nxt
);

  logic [CFG_W-1:0]   drop_frames_r, drop_frames_nxt;
  logic [CFG_W-1:0]   drop_hold_r, drop_hold_nxt;
  logic [LEVEL_W-1:0] cur_level_r, cur_level_nxt;
  logic [LEVEL_W-1:0] cand_level_r, cand_level_nxt;
  logic [COUNT_W-1:0] cand_count_r, cand_count_nxt;
  logic [TIME_W-1:0]  cand_since_r, cand_since_nxt;

  logic [LEVEL_W-1:0] raw;
  logic [COUNT_W-1:0] count_inc;
  logic [TIME_W-1:0]  elapsed;
  logic               frames_ok;
  logic               time_ok;

  always_comb begin
    drop_frames_nxt = drop_frames_r;
    drop_hold_nxt   = drop_hold_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DROP_FRAMES: drop_frames_nxt = cfg_wdata;
        CFG_DROP_HOLD:   drop_hold_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign raw       = (item.raw_level > TOP_LEVEL) ? TOP_LEVEL : item.raw_level;
  assign count_inc = (&cand_count_r) ? cand_count_r : cand_count_r + COUNT_W'(1);
  assign elapsed   = item.now_ms - cand_since_r;
  assign frames_ok = COUNT_W'(count_inc) >= COUNT_W'(drop_frames_r);
  assign time_ok   = (item.now_ms < cand_since_r) ? (drop_hold_r == '0)
                                                  : (elapsed >= TIME_W'(drop_hold_r));

  always_comb begin
    cur_level_nxt  = cur_level_r;
    cand_level_nxt = cand_level_r;
    cand_count_nxt = cand_count_r;
    cand_since_nxt = cand_since_r;
    if (step) begin
      priority if (raw > cur_level_r) begin
        cur_level_nxt  = raw;
        cand_level_nxt = raw;
        cand_count_nxt = '0;
        cand_since_nxt = item.now_ms;
      end else if (raw == cur_level_r) begin
        cand_level_nxt = cur_level_r;
        cand_count_nxt = '0;
        cand_since_nxt = item.now_ms;
      end else if (raw != cand_level_r) begin
        cand_level_nxt = raw;
        cand_count_nxt = COUNT_W'(1);
        cand_since_nxt = item.now_ms;
      end else if (frames_ok && time_ok) begin
        cur_level_nxt  = cand_level_r;
        cand_count_nxt = '0;
        cand_since_nxt = item.now_ms;
      end else begin
        cand_count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_frames_r <= DROP_FRAMES_RST;
      drop_hold_r   <= DROP_HOLD_RST;
      cur_level_r   <= TOP_LEVEL;
      cand_level_r  <= TOP_LEVEL;
      cand_count_r  <= '0;
      cand_since_r  <= '0;
    end else begin
      drop_frames_r <= drop_frames_nxt;
      drop_hold_r   <= drop_hold_nxt;
      cur_level_r   <= cur_level_nxt;
      cand_level_r  <= cand_level_nxt;
      cand_count_r  <= cand_count_nxt;
      cand_since_r  <= cand_since_nxt;
    end
  end

  assign level_nxt = cur_level_nxt;

endmodule

// ===== hdl/asymmetric_level_debounce_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asymmetric_level_debounce_top
// Registers: an accepted input word passes the input reg, then the result reg.
// Throughput: one word per cycle while out_stall is low; the state update is one
// compare-and-update step between the input register and the result register.
// Reset: synchronous; held and candidate level go to top, count and time to
// zero, the frame threshold to 3 and the hold time to 200 ms.
// ----------------------------------------------------------------------------
module asymmetric_level_debounce_top
  import ald_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LEVEL_W-1:0]   in_raw_level,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LEVEL_W-1:0]   out_held_level
);

  logic               item_valid;
  item_t              item;
  logic               advance;
  logic [LEVEL_W-1:0] level_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;

  assign advance = item_valid && (!out_valid_r || !out_stall);

  ald_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_raw_level (in_raw_level),
    .in_now_ms    (in_now_ms),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  ald_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item),
    .level_nxt (level_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = level_nxt;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_level_r <= out_level_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_held_level = out_level_r;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for asymmetric_level_debounce_top. Raw level words go
// through a randomly idling driver. Each accepted word runs through a local
// debounce model that predicts the held level. A randomly stalling monitor
// checks every result word against the oldest prediction. Register settings
// change between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module testbench;
  import ald_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DROP_FRAMES;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   in_raw_level = '0;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LEVEL_W-1:0]   out_held_level;

  asymmetric_level_debounce_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_level   (in_raw_level),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_held_level (out_held_level)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // debounce model state and register copies
  logic [LEVEL_W-1:0] held_lvl = TOP_LEVEL;
  logic [LEVEL_W-1:0] cand_lvl = TOP_LEVEL;
  logic [COUNT_W-1:0] cand_cnt = '0;
  logic [TIME_W-1:0]  cand_since = '0;
  logic [CFG_W-1:0]   frames_cfg = DROP_FRAMES_RST;
  logic [CFG_W-1:0]   hold_cfg = DROP_HOLD_RST;

  item_t              obs_q[$];
  logic [LEVEL_W-1:0] held_q[$];
  int                 err_count = 0;
  int                 cycle_count = 0;
  bit                 idle_en = 1'b1;
  int                 src_gap = 0;
  int                 sink_gap = 0;
  logic [TIME_W-1:0]  time_cursor = '0;

  function automatic logic [LEVEL_W-1:0] debounce_predict(logic [LEVEL_W-1:0] raw_in,
                                                          logic [TIME_W-1:0] now);
    logic [LEVEL_W-1:0] raw;
    logic [TIME_W-1:0]  elapsed;
    raw = (raw_in > TOP_LEVEL) ? TOP_LEVEL : raw_in;
    if (raw > held_lvl) begin
      held_lvl = raw;
      cand_lvl = raw;
      cand_cnt = '0;
      cand_since = now;
    end else if (raw == held_lvl) begin
      cand_lvl = held_lvl;
      cand_cnt = '0;
      cand_since = now;
    end else if (raw != cand_lvl) begin
      cand_lvl = raw;
      cand_cnt = COUNT_W'(1);
      cand_since = now;
    end else begin
      if (cand_cnt != '1) cand_cnt = cand_cnt + 1'b1;
      elapsed = (now >= cand_since) ? now - cand_since : '0;
      if (cand_cnt >= frames_cfg && elapsed >= hold_cfg) begin
        held_lvl = cand_lvl;
        cand_cnt = '0;
        cand_since = now;
      end
    end
    return held_lvl;
  endfunction

  task automatic report_err(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    item_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        held_q.push_back(debounce_predict(in_raw_level, in_now_ms));
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (obs_q.size() > 0) begin
          w = obs_q.pop_front();
          in_valid <= 1'b1;
          in_raw_level <= w.raw_level;
          in_now_ms <= w.now_ms;
          if (idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [LEVEL_W-1:0] exp_lvl;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (held_q.size() == 0) begin
          report_err($sformatf("unexpected word, held_level %0d", out_held_level));
        end else begin
          exp_lvl = held_q.pop_front();
          if (out_held_level !== exp_lvl)
            report_err($sformatf("held_level expected %0d got %0d", exp_lvl, out_held_level));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_word(logic [LEVEL_W-1:0] raw, logic [TIME_W-1:0] now);
    item_t w;
    w.raw_level = raw;
    w.now_ms = now;
    obs_q.push_back(w);
  endtask

  task automatic wait_drain();
    do @(negedge clk); while (obs_q.size() != 0 || in_valid || held_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DROP_FRAMES: frames_cfg = val;
      CFG_DROP_HOLD:   hold_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] frames, logic [CFG_W-1:0] hold);
    write_reg(CFG_DROP_FRAMES, frames);
    write_reg(CFG_DROP_HOLD, hold);
    @(negedge clk);
  endtask

  // mostly runs of one level with advancing time, plus noise and time jumps
  task automatic random_phase(int n_words);
    int         sent;
    int         run_len;
    int         run_max;
    int         step_max;
    logic [1:0] lvl;
    sent = 0;
    step_max = (int'(hold_cfg) / ((frames_cfg == 0) ? 1 : int'(frames_cfg))) * 2 + 2;
    run_max = (int'(frames_cfg) + 4 < 24) ? int'(frames_cfg) + 4 : 24;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(2'($urandom_range(0, 3)), $urandom());
        sent++;
      end else begin
        lvl = 2'($urandom_range(0, 3));
        run_len = $urandom_range(1, run_max);
        repeat (run_len) begin
          if ($urandom_range(0, 19) == 0)
            push_word(lvl, time_cursor - TIME_W'($urandom_range(1, step_max)));
          else begin
            time_cursor = time_cursor + TIME_W'($urandom_range(0, step_max));
            push_word(lvl, time_cursor);
          end
          sent++;
        end
      end
    end
    wait_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values: release after 3 frames and 200 ms
    push_word(2'd1, 32'd0);
    push_word(2'd1, 32'd100);
    push_word(2'd1, 32'd150);
    push_word(2'd1, 32'd250);
    push_word(2'd3, 32'd260);
    push_word(2'd0, 32'd1000);
    push_word(2'd0, 32'd500);
    push_word(2'd0, 32'hFFFF_FFFF);
    push_word(2'd0, 32'd5);
    push_word(2'd1, 32'hFFFF_0000);
    push_word(2'd0, 32'hFFFF_0001);
    push_word(2'd1, 32'hFFFF_0002);
    push_word(2'd0, 32'hFFFF_0003);
    push_word(2'd2, 32'hFFFF_0004);
    push_word(2'd1, 32'h5555_5555);
    push_word(2'd0, 32'hAAAA_AAAA);
    push_word(2'd0, 32'hAAAA_AB00);
    push_word(2'd0, 32'hAAAA_AC00);
    push_word(2'd0, 32'hAAAA_AD00);
    wait_drain();

    set_regs('0, '0);
    random_phase(250);
    idle_en = 1'b0;
    set_regs('1, '1);
    random_phase(250);
    idle_en = 1'b1;
    set_regs(16'd1, 16'd0);
    random_phase(250);
    set_regs(16'd4, 16'd100);
    random_phase(250);
    repeat (3) begin
      set_regs(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 300)));
      random_phase(250);
    end

    // hold time unreached: frame count passes the threshold, release waits
    set_regs(16'd4, 16'd1000);
    push_word(2'd2, 32'd0);
    repeat (20) push_word(2'd1, 32'd10);
    push_word(2'd1, 32'd1010);
    push_word(2'd0, 32'd1011);
    wait_drain();

    idle_en = 1'b0;
    set_regs(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 250)));
    random_phase(250);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
